FILE: sv/msct_pkg.sv
// Shared types and constants for the multi-slot callback timer.
package msct_pkg;

    localparam int DEF_TIMER_SLOTS = 16;
    // expiries reported per tick; later ones wait for the next tick
    localparam int MAX_EXPIRY = 16;
    localparam int EXP_CNT_W = $clog2(MAX_EXPIRY + 1);

    localparam logic [2:0] OP_SET   = 3'd0;
    localparam logic [2:0] OP_DEL   = 3'd1;
    localparam logic [2:0] OP_RESET = 3'd2;
    localparam logic [2:0] OP_STOP  = 3'd3;
    localparam logic [2:0] OP_START = 3'd4;
    localparam logic [2:0] OP_TICK  = 3'd5;
    localparam logic [2:0] OP_QUERY = 3'd6;

    localparam logic [1:0] MODE_ONCE         = 2'd0;
    localparam logic [1:0] MODE_PERIODIC     = 2'd1;
    localparam logic [1:0] MODE_PERIODIC_IMM = 2'd2;

    localparam logic [1:0] RESET_RESTART = 2'd1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    localparam logic KIND_REPLY  = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CMD_RD,
        ST_CMD_EXEC,
        ST_TICK_RD,
        ST_TICK_EVAL,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic load_cmd;
        logic idx_clr;
        logic idx_inc;
        logic rd_idx;
        logic do_set;
        logic do_full;
        logic do_cmd;
        logic do_tick;
        logic do_flush;
    } ctrl_cmd_t;

    typedef struct packed {
        logic idx_free;
        logic idx_last;
        logic out_free;
        logic tick_hold;
        logic flush_hold;
    } dp_stat_t;

endpackage

FILE: sv/multi_slot_callback_timer.sv
// Top level of the multi-slot callback timer pool.
//
//   channel | direction | beat contents
//   s_      | in        | opcode, slot_id, period_ms, mode_option, user_tag
//   m_      | out       | result_kind, status, slot_out, value_out, tag_out, last
//
// One command beat at a time: s_ready is high only while the sequencer is idle.
// Delete, reset, stop, start and query read the slot, then execute; set scans the
// slots upward from slot 0 and takes the first free one, or reports full.
// A tick walks every slot through the slot memories' read port, reading then
// evaluating each slot; each expiry beat waits for m_ready when stalled.
// Reset clears the valid and run marks at once; no clearing pass is needed.
module multi_slot_callback_timer #(
    parameter int TIMER_SLOTS = msct_pkg::DEF_TIMER_SLOTS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_opcode,
    input  logic [3:0]  s_slot_id,
    input  logic [31:0] s_period_ms,
    input  logic [1:0]  s_mode_option,
    input  logic [31:0] s_user_tag,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_result_kind,
    output logic [1:0]  m_status,
    output logic [3:0]  m_slot_out,
    output logic [31:0] m_value_out,
    output logic [31:0] m_tag_out,
    output logic        m_last
);
    import msct_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    msct_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_opcode (s_opcode),
        .stat     (stat),
        .cmd      (cmd)
    );

    msct_dp #(
        .TIMER_SLOTS (TIMER_SLOTS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .s_opcode      (s_opcode),
        .s_slot_id     (s_slot_id),
        .s_period_ms   (s_period_ms),
        .s_mode_option (s_mode_option),
        .s_user_tag    (s_user_tag),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_kind (m_result_kind),
        .m_status      (m_status),
        .m_slot_out    (m_slot_out),
        .m_value_out   (m_value_out),
        .m_tag_out     (m_tag_out),
        .m_last        (m_last)
    );

endmodule

FILE: sv/msct_ctrl.sv
// Sequencer for the timer pool: command decode, free-slot scan and tick walk.
module msct_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_opcode,
    input  msct_pkg::dp_stat_t stat,
    output msct_pkg::ctrl_cmd_t cmd
);
    import msct_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_cmd = 1'b1;
                    cmd.idx_clr  = 1'b1;
                    unique case (s_opcode)
                        OP_SET:   state_next = ST_SCAN;
                        OP_TICK:  state_next = ST_TICK_RD;
                        OP_DEL, OP_RESET, OP_STOP, OP_START, OP_QUERY:
                                  state_next = ST_CMD_RD;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN: begin
                cmd.rd_idx = 1'b1;
                priority if (stat.idx_free) begin
                    if (stat.out_free) begin
                        cmd.do_set = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else if (stat.idx_last) begin
                    if (stat.out_free) begin
                        cmd.do_full = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_CMD_RD: begin
                state_next = ST_CMD_EXEC;
            end
            ST_CMD_EXEC: begin
                if (stat.out_free) begin
                    cmd.do_cmd = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_TICK_RD: begin
                cmd.rd_idx = 1'b1;
                state_next = ST_TICK_EVAL;
            end
            ST_TICK_EVAL: begin
                cmd.rd_idx = 1'b1;
                if (!stat.tick_hold) begin
                    cmd.do_tick = 1'b1;
                    if (stat.idx_last) begin
                        state_next = ST_FLUSH;
                    end else begin
                        cmd.idx_inc = 1'b1;
                        state_next  = ST_TICK_RD;
                    end
                end
            end
            ST_FLUSH: begin
                if (!stat.flush_hold) begin
                    cmd.do_flush = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

FILE: sv/msct_dp.sv
// Slot storage, command latch, walk counter and result register of the timer pool.
module msct_dp #(
    parameter int TIMER_SLOTS = msct_pkg::DEF_TIMER_SLOTS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  msct_pkg::ctrl_cmd_t cmd,
    output msct_pkg::dp_stat_t  stat,
    input  logic [2:0]          s_opcode,
    input  logic [3:0]          s_slot_id,
    input  logic [31:0]         s_period_ms,
    input  logic [1:0]          s_mode_option,
    input  logic [31:0]         s_user_tag,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_result_kind,
    output logic [1:0]          m_status,
    output logic [3:0]          m_slot_out,
    output logic [31:0]         m_value_out,
    output logic [31:0]         m_tag_out,
    output logic                m_last
);
    import msct_pkg::*;

    localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

    // latched command beat
    logic [2:0]  op_reg;
    logic [3:0]  id_reg;
    logic [31:0] per_reg;
    logic [1:0]  opt_reg;
    logic [31:0] tag_reg;

    // slot flags
    logic [TIMER_SLOTS-1:0] valid_reg, valid_next;
    logic [TIMER_SLOTS-1:0] run_reg, run_next;

    // slot memories
    logic [1:0]  mode_mem [TIMER_SLOTS];
    logic [31:0] per_mem  [TIMER_SLOTS];
    logic [31:0] rem_mem  [TIMER_SLOTS];
    logic [31:0] tag_mem  [TIMER_SLOTS];
    logic [1:0]  rd_mode_reg;
    logic [31:0] rd_per_reg;
    logic [31:0] rd_rem_reg;
    logic [31:0] rd_tag_reg;

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] id_a;
    logic [IDX_W-1:0] addr;
    logic [EXP_CNT_W-1:0] cnt_reg, cnt_next;

    logic        we_mode, we_per, we_rem, we_tag;
    logic [1:0]  wd_mode;
    logic [31:0] wd_per, wd_rem;

    // held expiry: emitted once the next one shows whether it is the last
    logic        pend_reg, pend_next;
    logic [3:0]  pend_slot_reg, pend_slot_next;
    logic [31:0] pend_tag_reg, pend_tag_next;

    logic        out_valid_reg, out_valid_next;
    logic        out_load;
    logic        out_kind_reg, out_kind_next;
    logic [1:0]  out_status_reg, out_status_next;
    logic [3:0]  out_slot_reg, out_slot_next;
    logic [31:0] out_value_reg, out_value_next;
    logic [31:0] out_tag_reg, out_tag_next;
    logic        out_last_reg, out_last_next;

    logic in_range;
    logic active;
    logic due;
    logic expire;
    logic out_free;

    assign id_a     = IDX_W'(id_reg);
    assign addr     = cmd.rd_idx ? idx_reg : id_a;
    assign in_range = 8'(id_reg) < 8'(TIMER_SLOTS);
    assign out_free = !out_valid_reg || m_ready;

    assign active = valid_reg[idx_reg] && run_reg[idx_reg];
    assign due    = (rd_rem_reg[31:1] == 31'd0);
    assign expire = active && due && (cnt_reg < EXP_CNT_W'(MAX_EXPIRY));

    assign stat.idx_free   = !valid_reg[idx_reg];
    assign stat.idx_last   = (idx_reg == IDX_W'(TIMER_SLOTS - 1));
    assign stat.out_free   = out_free;
    assign stat.tick_hold  = expire && pend_reg && !out_free;
    assign stat.flush_hold = pend_reg && !out_free;

    always_ff @(posedge aclk) begin
        if (cmd.load_cmd) begin
            op_reg  <= s_opcode;
            id_reg  <= s_slot_id;
            per_reg <= s_period_ms;
            opt_reg <= s_mode_option;
            tag_reg <= s_user_tag;
        end
    end

    always_ff @(posedge aclk) begin
        if (we_mode) mode_mem[addr] <= wd_mode;
        if (we_per)  per_mem[addr]  <= wd_per;
        if (we_rem)  rem_mem[addr]  <= wd_rem;
        if (we_tag)  tag_mem[addr]  <= tag_reg;
        rd_mode_reg <= mode_mem[addr];
        rd_per_reg  <= per_mem[addr];
        rd_rem_reg  <= rem_mem[addr];
        rd_tag_reg  <= tag_mem[addr];
    end

    always_comb begin
        valid_next      = valid_reg;
        run_next        = run_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        we_mode         = 1'b0;
        we_per          = 1'b0;
        we_rem          = 1'b0;
        we_tag          = 1'b0;
        wd_mode         = MODE_ONCE;
        wd_per          = per_reg;
        wd_rem          = per_reg;
        pend_next       = pend_reg;
        pend_slot_next  = pend_slot_reg;
        pend_tag_next   = pend_tag_reg;
        out_load        = 1'b0;
        out_kind_next   = KIND_REPLY;
        out_status_next = STATUS_OK;
        out_slot_next   = id_reg;
        out_value_next  = 32'd0;
        out_tag_next    = 32'd0;
        out_last_next   = 1'b1;

        if (cmd.idx_clr) begin
            idx_next = '0;
            cnt_next = '0;
        end else if (cmd.idx_inc) begin
            idx_next = idx_reg + IDX_W'(1);
        end

        if (cmd.do_set) begin
            valid_next[idx_reg] = 1'b1;
            run_next[idx_reg]   = 1'b1;
            we_mode = 1'b1;
            we_per  = 1'b1;
            we_rem  = 1'b1;
            we_tag  = 1'b1;
            wd_mode = (opt_reg > MODE_PERIODIC_IMM) ? MODE_ONCE : opt_reg;
            wd_rem  = (opt_reg == MODE_PERIODIC_IMM) ? 32'd1 : per_reg;
            out_load      = 1'b1;
            out_slot_next = 4'(idx_reg);
        end

        if (cmd.do_full) begin
            out_load        = 1'b1;
            out_status_next = STATUS_FULL;
            out_slot_next   = 4'd0;
        end

        if (cmd.do_cmd) begin
            out_load = 1'b1;
            if (!in_range) begin
                out_status_next = STATUS_RANGE;
            end else begin
                unique case (op_reg)
                    OP_DEL: begin
                        valid_next[id_a] = 1'b0;
                        run_next[id_a]   = 1'b0;
                    end
                    OP_RESET: begin
                        we_per = (per_reg != 32'd0);
                        we_rem = (opt_reg == RESET_RESTART);
                        wd_rem = (per_reg != 32'd0) ? per_reg : rd_per_reg;
                    end
                    OP_STOP: begin
                        run_next[id_a] = 1'b0;
                    end
                    OP_START: begin
                        run_next[id_a] = 1'b1;
                        we_rem = 1'b1;
                        wd_rem = rd_per_reg;
                    end
                    OP_QUERY: begin
                        out_value_next = rd_rem_reg;
                    end
                    default: begin
                        out_load = 1'b0;
                    end
                endcase
            end
        end

        if (cmd.do_tick) begin
            if (expire) begin
                if (rd_mode_reg == MODE_ONCE) begin
                    valid_next[idx_reg] = 1'b0;
                    run_next[idx_reg]   = 1'b0;
                end else begin
                    we_rem = 1'b1;
                    wd_rem = rd_per_reg;
                end
                if (pend_reg) begin
                    out_load      = 1'b1;
                    out_kind_next = KIND_EXPIRY;
                    out_slot_next = pend_slot_reg;
                    out_tag_next  = pend_tag_reg;
                    out_last_next = 1'b0;
                end
                pend_next      = 1'b1;
                pend_slot_next = 4'(idx_reg);
                pend_tag_next  = rd_tag_reg;
                cnt_next       = cnt_reg + EXP_CNT_W'(1);
            end else if (active && !due) begin
                we_rem = 1'b1;
                wd_rem = rd_rem_reg - 32'd1;
            end
        end

        if (cmd.do_flush && pend_reg) begin
            out_load      = 1'b1;
            out_kind_next = KIND_EXPIRY;
            out_slot_next = pend_slot_reg;
            out_tag_next  = pend_tag_reg;
            out_last_next = 1'b1;
            pend_next     = 1'b0;
        end

        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            run_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            valid_reg     <= valid_next;
            run_reg       <= run_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg       <= idx_next;
        cnt_reg       <= cnt_next;
        pend_slot_reg <= pend_slot_next;
        pend_tag_reg  <= pend_tag_next;
        if (out_load) begin
            out_kind_reg   <= out_kind_next;
            out_status_reg <= out_status_next;
            out_slot_reg   <= out_slot_next;
            out_value_reg  <= out_value_next;
            out_tag_reg    <= out_tag_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_result_kind = out_kind_reg;
    assign m_status      = out_status_reg;
    assign m_slot_out    = out_slot_reg;
    assign m_value_out   = out_value_reg;
    assign m_tag_out     = out_tag_reg;
    assign m_last        = out_last_reg;

endmodule
